>>> hw/rtl/imi_pkg.sv
// shared operation codes for the interval merge insert block
`default_nettype none

package imi_pkg;

  // operation codes carried on the request
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } imi_op_t;

endpackage

`default_nettype wire

>>> hw/rtl/interval_merge_insert.sv
// interval table with merge-on-insert, clear and ordered read-out
// clear and unused codes: one result in the cycle after the request, busy stays low
// insert: scans the n stored entries, one entry per cycle
// through the shared compare unit, then appends the merged interval and registers the result
// read-out: entries stream in table order, one entry per cycle; an empty table gives a single result
// results cannot be stalled; a new request may be taken in the cycle a final result shows
// reset clears the entry count; table contents stay undefined and are read only below the count
`default_nettype none

module interval_merge_insert
  import imi_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         operation,
  input  wire logic [OFFSET_BITS-1:0]             first_offset,
  input  wire logic [OFFSET_BITS-1:0]             second_offset,
  output logic                                    result_valid,
  output logic [OFFSET_BITS-1:0]                  interval_start,
  output logic [OFFSET_BITS-1:0]                  interval_end,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]        entry_count,
  output logic                                    table_empty,
  output logic                                    overflow,
  output logic                                    last_result
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int W  = OFFSET_BITS;
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_READ
  } state_t;

  state_t        state;
  logic [CW-1:0] stored_count;
  logic [CW-1:0] n_cnt;
  logic [CW-1:0] chk_idx;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_idx;
  logic          any_abs;
  logic [W-1:0]  ms;
  logic [W-1:0]  me;

  // ram ports
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [2*W-1:0] wr_data;
  logic [IW-1:0]  rd_addr;
  logic [2*W-1:0] rd_data;

  imi_ram #(
    .WIDTH (2 * W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // request operands
  imi_op_t      req_op;
  logic         a_lt_b;
  logic [W-1:0] req_lo;
  logic [W-1:0] req_hi;

  assign req_op = imi_op_t'(operation);
  assign a_lt_b = first_offset < second_offset;
  assign req_lo = a_lt_b ? first_offset : second_offset;
  assign req_hi = a_lt_b ? second_offset : first_offset;

  // shared compare unit: current entry against merged interval
  logic [W-1:0] es;
  logic [W-1:0] ee;
  logic         ov;
  logic         adj;
  logic         absorb;
  logic [W-1:0] ms_next;
  logic [W-1:0] me_next;
  logic         chk_last;

  assign es       = rd_data[2*W-1:W];
  assign ee       = rd_data[W-1:0];
  assign ov       = (es <= me) && (ms <= ee);
  assign adj      = (({1'b0, me} + (W+1)'(1)) == {1'b0, es}) ||
                    (({1'b0, ee} + (W+1)'(1)) == {1'b0, ms});
  assign absorb   = ov || adj;
  assign ms_next  = (absorb && (es < ms)) ? es : ms;
  assign me_next  = (absorb && (ee > me)) ? ee : me;
  assign chk_last = (chk_idx + ONE) == n_cnt;

  // ram address and write control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[IW-1:0];
    wr_data = rd_data;
    rd_addr = (state == S_IDLE) ? '0 : rd_idx[IW-1:0];
    unique case (state)
      S_SCAN: begin
        wr_en = !absorb;
      end
      S_FINISH: begin
        wr_en   = any_abs || (n_cnt != FULL);
        wr_data = {ms, me};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign entry_count = stored_count;

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      result_valid <= 1'b0;
      n_cnt        <= '0;
      chk_idx      <= '0;
      rd_idx       <= '0;
      wr_idx       <= '0;
      any_abs      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n_cnt   <= stored_count;
            chk_idx <= '0;
            rd_idx  <= ONE;
            wr_idx  <= '0;
            any_abs <= 1'b0;
            ms      <= req_lo;
            me      <= req_hi;
            unique case (req_op)
              OP_CLEAR: begin
                stored_count   <= '0;
                result_valid   <= 1'b1;
                interval_start <= '0;
                interval_end   <= '0;
                table_empty    <= 1'b0;
                overflow       <= 1'b0;
                last_result    <= 1'b1;
              end
              OP_INSERT: begin
                state <= (stored_count == '0) ? S_FINISH : S_SCAN;
              end
              OP_READ: begin
                if (stored_count == '0) begin
                  result_valid   <= 1'b1;
                  interval_start <= '0;
                  interval_end   <= '0;
                  table_empty    <= 1'b1;
                  overflow       <= 1'b0;
                  last_result    <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              OP_NONE: begin
                result_valid   <= 1'b1;
                interval_start <= '0;
                interval_end   <= '0;
                table_empty    <= 1'b0;
                overflow       <= 1'b0;
                last_result    <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one entry per cycle, survivors close up in place
          ms      <= ms_next;
          me      <= me_next;
          any_abs <= any_abs || absorb;
          if (!absorb) begin
            wr_idx <= wr_idx + ONE;
          end
          chk_idx <= chk_idx + ONE;
          rd_idx  <= rd_idx + ONE;
          if (chk_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // append merged interval, or drop when full with nothing merged
          result_valid   <= 1'b1;
          interval_start <= ms;
          interval_end   <= me;
          table_empty    <= 1'b0;
          last_result    <= 1'b1;
          if (any_abs || (n_cnt != FULL)) begin
            stored_count <= wr_idx + ONE;
            overflow     <= 1'b0;
          end else begin
            overflow <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_READ: begin
          // stream one stored entry per cycle
          result_valid   <= 1'b1;
          interval_start <= es;
          interval_end   <= ee;
          table_empty    <= 1'b0;
          overflow       <= 1'b0;
          last_result    <= chk_last;
          chk_idx        <= chk_idx + ONE;
          rd_idx         <= rd_idx + ONE;
          if (chk_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= FULL)
    else $error("entry count above table depth");

  // a dropped insert only happens on a full table
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflow) |-> (entry_count == FULL))
    else $error("overflow reported on a table that is not full");

  // empty read-out only with no entries
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && table_empty) |-> (entry_count == '0))
    else $error("empty read-out with stored entries");

  // read-out streams without gaps until its last result
  a_stream: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |=> result_valid)
    else $error("gap inside read-out stream");

  // no new request is taken while a read-out is still streaming
  a_busy_stream: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> busy)
    else $error("idle while read-out results remain");

endmodule

`default_nettype wire

>>> hw/rtl/imi_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module imi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> tb/tb_interval_merge_insert.sv
// self-checking testbench for the interval merge insert block
`default_nettype none

module tb_interval_merge_insert import imi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int OFS_W        = 32;
  localparam int CNT_W        = 5;
  localparam int TARGET_ITEMS = 160;
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 40;

  // one result as seen on the output ports
  typedef struct packed {
    logic [OFS_W-1:0] lo;
    logic [OFS_W-1:0] hi;
    logic [CNT_W-1:0] entries;
    logic             empty;
    logic             ovf;
    logic             last;
  } interval_result_t;

  // table predictor plus queue of expected results
  class interval_checker;
    logic [OFS_W-1:0] starts [DEPTH];
    logic [OFS_W-1:0] ends [DEPTH];
    int unsigned stored;
    interval_result_t pending_results [$];
    int unsigned mismatches;

    function new();
      stored = 0;
      mismatches = 0;
    endfunction

    // a_end sits just below b_start, no wrap at the top
    function bit touches(logic [OFS_W-1:0] a_end, logic [OFS_W-1:0] b_start);
      return (a_end != '1) && (a_end + 1'b1 == b_start);
    endfunction

    function void push(logic [OFS_W-1:0] lo, logic [OFS_W-1:0] hi, bit empty, bit ovf,
                       bit last);
      interval_result_t r;
      r.lo = lo;
      r.hi = hi;
      r.entries = stored[CNT_W-1:0];
      r.empty = empty;
      r.ovf = ovf;
      r.last = last;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // update the table for an accepted request and queue its results
    function void note_request(imi_op_t op, logic [OFS_W-1:0] a, logic [OFS_W-1:0] b);
      logic [OFS_W-1:0] ms, me;
      bit absorbed [DEPTH];
      bit any;
      int unsigned i, w;
      case (op)
        OP_CLEAR: begin
          stored = 0;
          push('0, '0, 1'b0, 1'b0, 1'b1);
        end
        OP_INSERT: begin
          ms = (a < b) ? a : b;
          me = (a < b) ? b : a;
          any = 1'b0;
          for (i = 0; i < stored; i++) begin
            absorbed[i] = (starts[i] <= me && ms <= ends[i]) ||
                          touches(me, starts[i]) || touches(ends[i], ms);
            if (absorbed[i]) begin
              if (starts[i] < ms) ms = starts[i];
              if (ends[i] > me) me = ends[i];
              any = 1'b1;
            end
          end
          if (!any && stored >= DEPTH) begin
            push(ms, me, 1'b0, 1'b1, 1'b1);
          end else begin
            w = 0;
            for (i = 0; i < stored; i++) begin
              if (!absorbed[i]) begin
                starts[w] = starts[i];
                ends[w] = ends[i];
                w++;
              end
            end
            starts[w] = ms;
            ends[w] = me;
            stored = w + 1;
            push(ms, me, 1'b0, 1'b0, 1'b1);
          end
        end
        OP_READ: begin
          if (stored == 0) begin
            push('0, '0, 1'b1, 1'b0, 1'b1);
          end else begin
            for (i = 0; i < stored; i++)
              push(starts[i], ends[i], 1'b0, 1'b0, i + 1 == stored);
          end
        end
        default: begin
          push('0, '0, 1'b0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [OFS_W-1:0] got, logic [OFS_W-1:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    // compare one result against the oldest expectation
    task check_result(interval_result_t got);
      interval_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result start", got.lo, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.lo !== want.lo) report_mismatch("interval_start", got.lo, want.lo);
        if (got.hi !== want.hi) report_mismatch("interval_end", got.hi, want.hi);
        if (got.entries !== want.entries)
          report_mismatch("entry_count", got.entries, want.entries);
        if (got.empty !== want.empty) report_mismatch("table_empty", got.empty, want.empty);
        if (got.ovf !== want.ovf) report_mismatch("overflow", got.ovf, want.ovf);
        if (got.last !== want.last) report_mismatch("last_result", got.last, want.last);
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       operation;
  logic [OFS_W-1:0] first_offset;
  logic [OFS_W-1:0] second_offset;
  logic             result_valid;
  logic [OFS_W-1:0] interval_start;
  logic [OFS_W-1:0] interval_end;
  logic [CNT_W-1:0] entry_count;
  logic             table_empty;
  logic             overflow;
  logic             last_result;

  interval_checker sb;
  int unsigned     cycles = 0;
  int unsigned     items_sent;
  bit              burst_mode;

  interval_merge_insert #(
    .TABLE_DEPTH(DEPTH),
    .OFFSET_BITS(OFS_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .first_offset(first_offset),
    .second_offset(second_offset),
    .result_valid(result_valid),
    .interval_start(interval_start),
    .interval_end(interval_end),
    .entry_count(entry_count),
    .table_empty(table_empty),
    .overflow(overflow),
    .last_result(last_result)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    interval_result_t got;
    if (!rst && result_valid) begin
      got.lo = interval_start;
      got.hi = interval_end;
      got.entries = entry_count;
      got.empty = table_empty;
      got.ovf = overflow;
      got.last = last_result;
      sb.check_result(got);
    end
  end

  // drive one request and wait until it is taken
  task automatic issue(imi_op_t op, logic [OFS_W-1:0] a, logic [OFS_W-1:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    first_offset <= a;
    second_offset <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, a, b);
    if (op != OP_NONE) items_sent++;
  endtask

  // insert with the two offsets in random order
  task automatic insert_either(logic [OFS_W-1:0] lo, logic [OFS_W-1:0] hi);
    if ($urandom_range(0, 1)) issue(OP_INSERT, lo, hi);
    else issue(OP_INSERT, hi, lo);
  endtask

  // intervals on a grid after a clear, non-touching across slots; a repeated random slot may overlap or touch
  task automatic fill_table(int min_inserts);
    logic [OFS_W-1:0] prefix, lo;
    int n, slot, j, slot_b;
    prefix = $urandom & 32'hFFFF_FF00;
    issue(OP_CLEAR, $urandom, $urandom);
    n = $urandom_range(min_inserts, 19);
    for (j = 0; j < n; j++) begin
      slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : j;
      lo = prefix + slot * 8 + $urandom_range(0, 2);
      insert_either(lo, lo + $urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) issue(OP_READ, $urandom, $urandom);
    end
    issue(OP_READ, $urandom, $urandom);
    // one wide insert swallowing a run of entries
    if ($urandom_range(0, 1)) begin
      slot = $urandom_range(0, 20);
      slot_b = slot + $urandom_range(0, 10);
      insert_either(prefix + slot * 8, prefix + slot_b * 8 + 5);
      issue(OP_READ, $urandom, $urandom);
    end
  endtask

  // overlapping and touching intervals in a narrow window, some stretched to the ends of the range
  task automatic merge_run();
    logic [OFS_W-1:0] base, lo, hi, prev_hi;
    int n, j;
    case ($urandom_range(0, 2))
      0: base = '0;
      1: base = 32'hFFFF_FF00;
      default: base = $urandom;
    endcase
    prev_hi = base;
    n = $urandom_range(6, 12);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 3) == 0) lo = prev_hi + 1'b1;
      else lo = base + $urandom_range(0, 8'hC0);
      hi = lo + $urandom_range(0, 8'h3F);
      if ($urandom_range(0, 7) == 0) hi = '1;
      if ($urandom_range(0, 7) == 0) lo = '0;
      insert_either(lo, hi);
      prev_hi = (lo < hi) ? hi : lo;
      if ($urandom_range(0, 4) == 0) issue(OP_READ, $urandom, $urandom);
      if ($urandom_range(0, 15) == 0) issue(OP_CLEAR, $urandom, $urandom);
    end
    issue(OP_READ, $urandom, $urandom);
  endtask

  // main sequence
  initial begin
    int pick, k;
    sb = new();
    items_sent = 0;
    burst_mode = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_CLEAR;
    first_offset = '0;
    second_offset = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty read, unused code, touching on both sides, top of range
    issue(OP_READ, 32'h0, 32'h0);
    issue(OP_NONE, 32'hFFFF_FFFF, 32'h0);
    issue(OP_INSERT, 32'd20, 32'd10);
    issue(OP_INSERT, 32'd21, 32'd30);
    issue(OP_INSERT, 32'd9, 32'd5);
    issue(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    issue(OP_INSERT, 32'h0, 32'h0);
    issue(OP_INSERT, 32'hFFFF_FFEF, 32'hFFFF_FFEF);
    issue(OP_INSERT, 32'd1, 32'd4);
    issue(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'd32, 32'd40);
    issue(OP_INSERT, 32'd31, 32'd31);
    issue(OP_READ, 32'h0, 32'h0);
    issue(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_READ, 32'h0, 32'h0);
    issue(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'd7, 32'd7);
    issue(OP_READ, 32'h0, 32'h0);
    issue(OP_CLEAR, 32'h0, 32'h0);
    issue(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'h0, 32'h0);
    issue(OP_READ, 32'h0, 32'h0);

    // random: first pass issues 19 inserts, enough to overfill the table unless slots repeat
    fill_table(19);
    while (items_sent < TARGET_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        fill_table(14);
      end else if (pick < 8) begin
        merge_run();
      end else begin
        for (k = 0; k < $urandom_range(1, 4); k++)
          issue(imi_op_t'($urandom_range(0, 3)), $urandom, $urandom);
      end
    end

    // drain and finish
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
